// ----- rtl/dcsp_pkg.sv -----
// shared types, codes and constants of the delta chain shortest path block
package dcsp_pkg;

   localparam int DEF_MAX_DELTAS      = 16;
   localparam int DEF_VERSION_ID_BITS = 8;
   localparam int DEF_SIZE_BITS       = 32;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_SEARCH = 2'd2;

   localparam logic [1:0] ST_FOUND       = 2'd0;
   localparam logic [1:0] ST_NO_DELTA    = 2'd1;
   localparam logic [1:0] ST_UNREACHABLE = 2'd2;
   localparam logic [1:0] ST_OVERFLOW    = 2'd3;

   localparam logic [35:0] TOTAL_MAX = 36'hF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  from_version;
      logic [7:0]  to_version;
      logic [31:0] size_bytes;
      logic        delta_cached;
      logic        base_present;
      logic [7:0]  target_version;
   } req_type;

   typedef struct packed {
      logic [3:0]  delta_index;
      logic [35:0] total_size;
      logic [1:0]  status;
      logic        last_item;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic init;
      logic relax;
      logic is_best;
      logic active;
   } ctl_type;

endpackage

// ----- rtl/delta_chain_shortest_path.sv -----
// top level: delta table of cells, search sequencer and chain output
//
// channel | ports                      | direction | handshake
// req     | req_data, start, busy      | in        | start && !busy
// rsp     | rsp_data, rsp_strobe       | out       | strobe, one cycle, no stall
//
// clear and add never leave idle; a search with the overflow flag set answers next cycle.
// otherwise a search runs an init step, then a scan of the table and one relax step per reached
// delta, a closing scan, a target scan, a parent walk over the chain deltas and then the
// emission of the chain items.
// reset is synchronous and empties the table; busy is high while a search runs.
// the receiver cannot stall: each result item is shown for exactly one cycle.
module delta_chain_shortest_path #(
   parameter int MAX_DELTAS      = dcsp_pkg::DEF_MAX_DELTAS,
   parameter int VERSION_ID_BITS = dcsp_pkg::DEF_VERSION_ID_BITS,
   parameter int SIZE_BITS       = dcsp_pkg::DEF_SIZE_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dcsp_pkg::req_type req_data,
   output logic              rsp_strobe,
   output dcsp_pkg::rsp_type rsp_data
);
   import dcsp_pkg::*;

   localparam int VB = VERSION_ID_BITS;
   localparam int SB = SIZE_BITS;
   localparam int IB = (MAX_DELTAS > 1) ? $clog2(MAX_DELTAS) : 1;
   localparam int CB = $clog2(MAX_DELTAS + 1);
   localparam int WB = SB + IB + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_RELAX = 3'd3;
   localparam logic [2:0] S_TGT   = 3'd4;
   localparam logic [2:0] S_TRACE = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic          have_ff, have_in, any_ff, any_in;
   logic [IB-1:0] best_ff, best_in;
   logic [WB-1:0] bw_ff, bw_in;
   logic [VB-1:0] target_ff, target_in;
   logic [35:0]   total_ff, total_in;
   logic [IB-1:0] k_ff, k_in;
   logic [CB-1:0] len_ff, len_in;
   logic [IB-1:0] chain_ff [MAX_DELTAS];
   logic          chain_we;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [VB-1:0] c_to     [MAX_DELTAS];
   logic [WB-1:0] c_w      [MAX_DELTAS];
   logic          c_reach  [MAX_DELTAS];
   logic          c_done   [MAX_DELTAS];
   logic          c_pvalid [MAX_DELTAS];
   logic [IB-1:0] c_parent [MAX_DELTAS];
   ctl_type       ctl      [MAX_DELTAS];

   logic          do_write, do_init, do_relax;
   logic [VB+7:0] from_ext, to_ext, tgt_ext;
   logic [SB+31:0] size_ext;
   logic [SB-1:0] wr_cost;
   logic [IB-1:0] sel;
   logic [WB+35:0] bw_ext;
   logic [IB+3:0] out_ext;

   assign from_ext = {{VB{1'b0}}, req_data.from_version};
   assign to_ext   = {{VB{1'b0}}, req_data.to_version};
   assign tgt_ext  = {{VB{1'b0}}, req_data.target_version};
   assign size_ext = {{SB{1'b0}}, req_data.size_bytes};
   assign wr_cost  = req_data.delta_cached ? '0 : size_ext[SB-1:0];
   assign sel      = idx_ff[IB-1:0];
   assign bw_ext   = {36'b0, bw_ff};
   assign out_ext  = {4'b0, chain_ff[len_ff[IB-1:0]]};

   for (genvar g = 0; g < MAX_DELTAS; g++) begin : g_cell
      always_comb begin
         ctl[g].write   = do_write && (count_ff == CB'(g));
         ctl[g].init    = do_init;
         ctl[g].relax   = do_relax;
         ctl[g].is_best = (best_ff == IB'(g));
         ctl[g].active  = (CB'(g) < count_ff);
      end
      dcsp_cell #(.VB(VB), .SB(SB), .IB(IB), .WB(WB)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[g]),
         .wr_from    (from_ext[VB-1:0]),
         .wr_to      (to_ext[VB-1:0]),
         .wr_cost    (wr_cost),
         .wr_seeded  (req_data.base_present),
         .best_to    (c_to[best_ff]),
         .best_w     (bw_ff),
         .best_idx   (best_ff),
         .to_out     (c_to[g]),
         .weight_out (c_w[g]),
         .reached_out(c_reach[g]),
         .done_out   (c_done[g]),
         .pvalid_out (c_pvalid[g]),
         .parent_out (c_parent[g])
      );
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      have_in   = have_ff;
      any_in    = any_ff;
      best_in   = best_ff;
      bw_in     = bw_ff;
      target_in = target_ff;
      total_in  = total_ff;
      k_in      = k_ff;
      len_in    = len_ff;
      chain_we  = 1'b0;
      strobe_in = 1'b0;
      rsp_in    = '0;
      do_write  = 1'b0;
      do_init   = 1'b0;
      do_relax  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  CMD_ADD: begin
                     if (count_ff >= CB'(MAX_DELTAS)) begin
                        ovf_in = 1'b1;
                     end else begin
                        do_write = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     target_in = tgt_ext[VB-1:0];
                     if (ovf_ff) begin
                        strobe_in        = 1'b1;
                        rsp_in.status    = ST_OVERFLOW;
                        rsp_in.last_item = 1'b1;
                     end else begin
                        state_in = S_INIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            do_init  = 1'b1;
            idx_in   = '0;
            have_in  = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               idx_in  = '0;
               have_in = 1'b0;
               any_in  = 1'b0;
               state_in = have_ff ? S_RELAX : S_TGT;
            end else begin
               if (c_reach[sel] && !c_done[sel] && (!have_ff || c_w[sel] < bw_ff)) begin
                  best_in = sel;
                  bw_in   = c_w[sel];
                  have_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RELAX: begin
            do_relax = 1'b1;
            state_in = S_SCAN;
         end
         S_TGT: begin
            if (idx_ff == count_ff) begin
               if (!any_ff || !have_ff) begin
                  strobe_in        = 1'b1;
                  rsp_in.status    = !any_ff ? ST_NO_DELTA : ST_UNREACHABLE;
                  rsp_in.last_item = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  total_in = (bw_ext > {{WB{1'b0}}, TOTAL_MAX}) ? TOTAL_MAX : bw_ext[35:0];
                  k_in     = best_ff;
                  len_in   = '0;
                  state_in = S_TRACE;
               end
            end else begin
               if (c_to[sel] == target_ff) begin
                  any_in = 1'b1;
                  if (c_reach[sel] && (!have_ff || c_w[sel] < bw_ff)) begin
                     best_in = sel;
                     bw_in   = c_w[sel];
                     have_in = 1'b1;
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TRACE: begin
            chain_we = 1'b1;
            if (!c_pvalid[k_ff] || (len_ff + 1'b1) == CB'(MAX_DELTAS)) begin
               state_in = S_EMIT;
            end else begin
               k_in   = c_parent[k_ff];
               len_in = len_ff + 1'b1;
            end
         end
         S_EMIT: begin
            strobe_in          = 1'b1;
            rsp_in.delta_index = out_ext[3:0];
            rsp_in.total_size  = total_ff;
            rsp_in.status      = ST_FOUND;
            rsp_in.last_item   = (len_ff == '0);
            if (len_ff == '0) state_in = S_IDLE;
            else len_in = len_ff - 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      have_ff   <= have_in;
      any_ff    <= any_in;
      best_ff   <= best_in;
      bw_ff     <= bw_in;
      target_ff <= target_in;
      total_ff  <= total_in;
      k_ff      <= k_in;
      len_ff    <= len_in;
      rsp_ff    <= rsp_in;
      if (chain_we) chain_ff[len_ff[IB-1:0]] <= k_ff;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_FOUND |-> rsp_data.last_item)
      else $error("status item without last_item");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(MAX_DELTAS))
      else $error("table count beyond depth");
   a_add_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd == CMD_ADD |=> !rsp_strobe)
      else $error("add produced a result");
   a_chain_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_FOUND && !rsp_data.last_item |=> rsp_strobe)
      else $error("chain items not back to back");

endmodule

// ----- rtl/dcsp_cell.sv -----
// one table cell: holds one delta and relaxes its own weight against the broadcast vertex
module dcsp_cell #(
   parameter int VB = dcsp_pkg::DEF_VERSION_ID_BITS,
   parameter int SB = dcsp_pkg::DEF_SIZE_BITS,
   parameter int IB = 4,
   parameter int WB = 37
) (
   input  logic                clock,
   input  logic                reset,
   input  dcsp_pkg::ctl_type   ctl,
   input  logic [VB-1:0]       wr_from,
   input  logic [VB-1:0]       wr_to,
   input  logic [SB-1:0]       wr_cost,
   input  logic                wr_seeded,
   input  logic [VB-1:0]       best_to,
   input  logic [WB-1:0]       best_w,
   input  logic [IB-1:0]       best_idx,
   output logic [VB-1:0]       to_out,
   output logic [WB-1:0]       weight_out,
   output logic                reached_out,
   output logic                done_out,
   output logic                pvalid_out,
   output logic [IB-1:0]       parent_out
);
   import dcsp_pkg::*;

   logic [VB-1:0] from_ff, to_ff;
   logic [SB-1:0] cost_ff;
   logic          seeded_ff;
   logic [WB-1:0] weight_ff;
   logic          reached_ff, done_ff, pvalid_ff;
   logic [IB-1:0] parent_ff;
   logic [WB-1:0] cand_in;

   assign cand_in = best_w + WB'(cost_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff <= 1'b0;
         done_ff    <= 1'b0;
         pvalid_ff  <= 1'b0;
      end else if (ctl.init) begin
         reached_ff <= seeded_ff && ctl.active;
         done_ff    <= 1'b0;
         pvalid_ff  <= 1'b0;
      end else if (ctl.relax) begin
         if (ctl.is_best) done_ff <= 1'b1;
         if (ctl.active && from_ff == best_to && (!reached_ff || weight_ff > cand_in)) begin
            reached_ff <= 1'b1;
            pvalid_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         from_ff   <= wr_from;
         to_ff     <= wr_to;
         cost_ff   <= wr_cost;
         seeded_ff <= wr_seeded;
      end
      if (ctl.init) begin
         weight_ff <= seeded_ff ? WB'(cost_ff) : '0;
      end else if (ctl.relax) begin
         if (ctl.active && from_ff == best_to && (!reached_ff || weight_ff > cand_in)) begin
            weight_ff <= cand_in;
            parent_ff <= best_idx;
         end
      end
   end

   assign to_out      = to_ff;
   assign weight_out  = weight_ff;
   assign reached_out = reached_ff;
   assign done_out    = done_ff;
   assign pvalid_out  = pvalid_ff;
   assign parent_out  = parent_ff;

endmodule
